[hw/rtl/spd_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo ping-pong delay package
// Shared types, register indexes, sequencer step codes and fixed constants.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Configuration registers are all 16 bits wide.
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Filter states carry the sample with this many extra fraction bits.
  localparam int FILT_EXTRA = 8;

  localparam logic [COEF_W-1:0] UNITY_Q15 = 16'h8000;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_AMOUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_COEFF = 3'd4;

  // Register reset values.
  localparam int                DELAY_LENGTH_RESET   = 24000;
  localparam logic [COEF_W-1:0] FEEDBACK_GAIN_RESET  = 16'd16384;
  localparam logic [COEF_W-1:0] PAN_AMOUNT_RESET     = 16'd16384;
  localparam logic [COEF_W-1:0] LOWPASS_COEFF_RESET  = 16'd32768;
  localparam logic [COEF_W-1:0] HIGHPASS_COEFF_RESET = 16'd128;

  // Sequencer steps. Each step from ST_LP_L to ST_FB_R issues one multiply on the shared unit.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_LP_L  = 4'd1;  // low-pass multiply, left
  localparam logic [STEP_W-1:0] ST_LP_R  = 4'd2;  // low-pass multiply, right
  localparam logic [STEP_W-1:0] ST_HP_L  = 4'd3;  // high-pass multiply, left
  localparam logic [STEP_W-1:0] ST_HP_R  = 4'd4;  // high-pass multiply, right
  localparam logic [STEP_W-1:0] ST_PAN_L = 4'd5;  // pan multiply, left
  localparam logic [STEP_W-1:0] ST_PAN_R = 4'd6;  // pan multiply, right
  localparam logic [STEP_W-1:0] ST_FB_L  = 4'd7;  // feedback multiply, left
  localparam logic [STEP_W-1:0] ST_FB_R  = 4'd8;  // feedback multiply, right
  localparam logic [STEP_W-1:0] ST_OUT   = 4'd9;  // result and right store write

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              mul_en;
  } spd_ctrl_t;

  typedef struct packed {
    logic [COEF_W-1:0] lowpass;
    logic [COEF_W-1:0] highpass;
    logic [COEF_W-1:0] pan;
    logic [COEF_W-1:0] feedback;
  } spd_coef_t;

endpackage

[hw/rtl/spd_in_if.sv]
// ----------------------------------------------------------------------------
// Stereo frame input channel
// Valid/ready channel carrying one left and one right input sample.
// ----------------------------------------------------------------------------
interface spd_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

[hw/rtl/spd_out_if.sv]
// ----------------------------------------------------------------------------
// Stereo frame result channel
// Valid/ready channel carrying one left and one right output sample.
// ----------------------------------------------------------------------------
interface spd_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] out_left;
  logic signed [SAMPLE_BITS:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

[hw/rtl/stereo_ping_pong_delay.sv]
// ----------------------------------------------------------------------------
// Stereo ping-pong delay with tone filter
// Top level: configuration registers, sequencer, delay stores and output.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  in_ch     sink       valid / ready           in_left, in_right (Q1.15)
//  out_ch    source     valid / ready           out_left, out_right (Q2.15)
//  cfg_*     input      cfg_we, no wait         cfg_index, cfg_data (16 bits)
//
// From acceptance until the block is ready again, a frame passes through
// the acceptance cycle, which also issues the delay store reads, and nine
// sequencer steps that share a single multiplier (eight multiplies).
// The result is registered; the block takes the next transaction while it
// waits, and stalls only in its last step when the previous result is still
// not taken. A write of delay_length reduces it modulo the store depth;
// while the reduction runs, no transaction is accepted.
// Reset is synchronous; there is no clearing pass over the stores. Slots not
// yet written since reset read as zero, tracked by the write position and a
// wrap flag, since the store is written strictly in order.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay #(
  parameter int DELAY_DEPTH = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  spd_in_if.sink                        in_ch,
  spd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::COEF_W-1:0]    cfg_data
);
  import spd_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int DW  = (AW > COEF_W) ? AW : COEF_W;
  localparam int SW  = DW + 2;
  localparam logic [COEF_W-1:0] DMOD_RESET = COEF_W'(DELAY_LENGTH_RESET % DELAY_DEPTH);

  // Reciprocal of the store depth for the delay length reduction. The
  // quotient estimate is at most one below the true quotient.
  localparam int RCP_SHIFT = 32;
  localparam logic [RCP_SHIFT-1:0] DMOD_RCP =
    RCP_SHIFT'((64'd1 << RCP_SHIFT) / DELAY_DEPTH);
  localparam int MQW = COEF_W + RCP_SHIFT;
  localparam int QDW = COEF_W + $clog2(DELAY_DEPTH + 1);

  // Configuration registers. The delay length is kept already reduced
  // modulo the store depth.
  logic [COEF_W-1:0] dmod_r, fb_r, pan_r, lpc_r, hpc_r;

  // Reduction of a new delay length: a reciprocal multiply gives a quotient
  // estimate, a multiply and subtract gives a remainder below twice the
  // depth, and one compare and subtract finishes it.
  logic                red_start;
  logic                red_busy_r;
  logic [1:0]          red_k_r;
  logic [COEF_W-1:0]   red_rem_r;
  logic [COEF_W-1:0]   red_q_r;
  logic [MQW-1:0]      red_mq;
  logic [QDW-1:0]      red_qd;
  logic [COEF_W-1:0]   red_rem_nxt;

  logic [STEP_W-1:0]   state_r, state_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic                wrapped_r;
  logic [SW-1:0]       rp_sum;
  logic [AW-1:0]       rp;
  logic                rd_fresh;
  logic                rd_valid_r;

  logic signed [SB-1:0] x_l_r, x_r_r;
  logic signed [SB-1:0] rd_l, rd_r;
  logic [SB-1:0]        q_l, q_r;
  logic [SB-1:0]        wr_sample;

  logic                 out_valid_r;
  logic signed [SB:0]   out_l_r, out_r_r;

  logic       in_fire;
  logic       out_go;
  spd_ctrl_t  ctrl;
  spd_coef_t  coef;

  assign in_ch.ready = (state_r == ST_IDLE) && !red_busy_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_go      = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign red_start   = cfg_we && (cfg_index == REG_DELAY_LENGTH);
  assign red_mq      = MQW'(red_rem_r) * MQW'(DMOD_RCP);
  assign red_qd      = QDW'(red_q_r) * QDW'(DELAY_DEPTH);
  assign red_rem_nxt = (SW'(red_rem_r) >= SW'(DELAY_DEPTH)) ?
                       (red_rem_r - COEF_W'(DELAY_DEPTH)) : red_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmod_r     <= DMOD_RESET;
      fb_r       <= FEEDBACK_GAIN_RESET;
      pan_r      <= PAN_AMOUNT_RESET;
      lpc_r      <= LOWPASS_COEFF_RESET;
      hpc_r      <= HIGHPASS_COEFF_RESET;
      red_busy_r <= 1'b0;
      red_k_r    <= '0;
      red_rem_r  <= '0;
      red_q_r    <= '0;
    end else begin
      if (red_start) begin
        red_rem_r  <= cfg_data;
        red_k_r    <= 2'd2;
        red_busy_r <= 1'b1;
      end else if (red_busy_r) begin
        red_k_r <= red_k_r - 2'd1;
        case (red_k_r)
          2'd2:    red_q_r   <= red_mq[MQW-1:RCP_SHIFT];
          2'd1:    red_rem_r <= red_rem_r - red_qd[COEF_W-1:0];
          default: begin
            dmod_r     <= red_rem_nxt;
            red_busy_r <= 1'b0;
          end
        endcase
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DELAY_LENGTH: begin
          end
          REG_FEEDBACK_GAIN:  fb_r  <= cfg_data;
          REG_PAN_AMOUNT:     pan_r <= cfg_data;
          REG_LOWPASS_COEFF:  lpc_r <= cfg_data;
          REG_HIGHPASS_COEFF: hpc_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Read position and fill tracking
  // --------------------------------------------------------------------------
  // The read position trails the write position by the reduced delay length.
  // A zero length reads the slot about to be written, before it is written.
  assign rp_sum   = SW'(wp_r) + SW'(DELAY_DEPTH) - SW'(dmod_r);
  assign rp       = (rp_sum >= SW'(DELAY_DEPTH)) ? AW'(rp_sum - SW'(DELAY_DEPTH))
                                                 : AW'(rp_sum);
  assign rd_fresh = wrapped_r || (rp < wp_r);
  assign wp_nxt   = (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + AW'(1);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  state_nxt = in_fire ? ST_LP_L : ST_IDLE;
      ST_LP_L:  state_nxt = ST_LP_R;
      ST_LP_R:  state_nxt = ST_HP_L;
      ST_HP_L:  state_nxt = ST_HP_R;
      ST_HP_R:  state_nxt = ST_PAN_L;
      ST_PAN_L: state_nxt = ST_PAN_R;
      ST_PAN_R: state_nxt = ST_FB_L;
      ST_FB_L:  state_nxt = ST_FB_R;
      ST_FB_R:  state_nxt = ST_OUT;
      ST_OUT:   state_nxt = out_go ? ST_IDLE : ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_go || (out_valid_r && !out_ch.ready);
      if (out_go) begin
        wp_r <= wp_nxt;
        if (wp_r == AW'(DELAY_DEPTH - 1)) begin
          wrapped_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_l_r      <= in_ch.in_left;
      x_r_r      <= in_ch.in_right;
      rd_valid_r <= rd_fresh;
    end
    if (out_go) begin
      out_l_r <= {rd_l[SB-1], rd_l} + {x_l_r[SB-1], x_l_r};
      out_r_r <= {rd_r[SB-1], rd_r} + {x_r_r[SB-1], x_r_r};
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_left  = out_l_r;
  assign out_ch.out_right = out_r_r;

  // --------------------------------------------------------------------------
  // Delay stores. Both are read at acceptance; left is written in the last
  // feedback step, right together with the result.
  // --------------------------------------------------------------------------
  spd_ram #(
    .WIDTH (SB),
    .DEPTH (DELAY_DEPTH)
  ) u_left_store (
    .clk   (clk),
    .we    (state_r == ST_FB_R),
    .waddr (wp_r),
    .wdata (wr_sample),
    .re    (in_fire),
    .raddr (rp),
    .rdata (q_l)
  );

  spd_ram #(
    .WIDTH (SB),
    .DEPTH (DELAY_DEPTH)
  ) u_right_store (
    .clk   (clk),
    .we    (out_go),
    .waddr (wp_r),
    .wdata (wr_sample),
    .re    (in_fire),
    .raddr (rp),
    .rdata (q_r)
  );

  // A slot not written since reset reads as zero.
  assign rd_l = rd_valid_r ? $signed(q_l) : '0;
  assign rd_r = rd_valid_r ? $signed(q_r) : '0;

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  assign ctrl.step   = state_r;
  assign ctrl.mul_en = (state_r != ST_IDLE) && (state_r != ST_OUT);

  assign coef.lowpass  = lpc_r;
  assign coef.highpass = hpc_r;
  assign coef.pan      = pan_r;
  assign coef.feedback = fb_r;

  spd_datapath #(
    .SAMPLE_BITS (SB)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .coef      (coef),
    .x_left    (x_l_r),
    .x_right   (x_r_r),
    .rd_left   (rd_l),
    .rd_right  (rd_r),
    .wr_sample (wr_sample)
  );

endmodule

[hw/rtl/spd_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/spd_datapath.sv]
// ----------------------------------------------------------------------------
// Stereo ping-pong delay datapath
// Shared multiplier, tone filter states and feedback accumulators.
// ----------------------------------------------------------------------------
module spd_datapath #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spd_pkg::spd_ctrl_t            ctrl,
  input  spd_pkg::spd_coef_t            coef,
  input  logic signed [SAMPLE_BITS-1:0] x_left,
  input  logic signed [SAMPLE_BITS-1:0] x_right,
  input  logic signed [SAMPLE_BITS-1:0] rd_left,
  input  logic signed [SAMPLE_BITS-1:0] rd_right,
  output logic        [SAMPLE_BITS-1:0] wr_sample
);
  import spd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int FW = SB + FILT_EXTRA;  // filter state
  localparam int ZW = FW + 1;           // filter differences
  localparam int AW = SB + 11;          // multiplier operand A / accumulator
  localparam int BW = COEF_W + 1;       // multiplier operand B
  localparam int PW = AW + BW;          // product

  localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  logic signed [FW-1:0] lp_l_r, lp_r_r, hp_l_r, hp_r_r;
  logic signed [AW-1:0] acc_l_r, acc_r_r;
  logic signed [PW-1:0] prod_r;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [FW-1:0] x8_l, x8_r;
  logic signed [ZW-1:0] dlp_l, dlp_r, dhp_l, dhp_r;
  logic signed [FW-1:0] sh16;
  logic signed [AW-1:0] sh14;
  logic signed [PW-1:0] sh23;
  logic signed [AW-1:0] fb_l, fb_r;
  logic [COEF_W-1:0]    pan_c, fb_c;

  always_comb begin
    x8_l  = {x_left,  {FILT_EXTRA{1'b0}}};
    x8_r  = {x_right, {FILT_EXTRA{1'b0}}};
    dlp_l = {x8_l[FW-1], x8_l} - {lp_l_r[FW-1], lp_l_r};
    dlp_r = {x8_r[FW-1], x8_r} - {lp_r_r[FW-1], lp_r_r};
    dhp_l = {lp_l_r[FW-1], lp_l_r} - {hp_l_r[FW-1], hp_l_r};
    dhp_r = {lp_r_r[FW-1], lp_r_r} - {hp_r_r[FW-1], hp_r_r};
    pan_c = (coef.pan > UNITY_Q15) ? UNITY_Q15 : coef.pan;
    fb_c  = (coef.feedback > UNITY_Q15) ? UNITY_Q15 : coef.feedback;

    // Arithmetic shifts of the product round toward minus infinity.
    sh16 = FW'(prod_r >>> 16);
    sh14 = AW'(prod_r >>> 14);
    sh23 = prod_r >>> (15 + FILT_EXTRA);

    // Opposite channel's delayed sample, aligned to the filter scale.
    fb_l = {{(AW-FW){rd_right[SB-1]}}, rd_right, {FILT_EXTRA{1'b0}}} + sh14;
    fb_r = {{(AW-FW){rd_left[SB-1]}},  rd_left,  {FILT_EXTRA{1'b0}}} + sh14;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.step)
      ST_LP_L: begin
        mul_a = {{(AW-ZW){dlp_l[ZW-1]}}, dlp_l};
        mul_b = {1'b0, coef.lowpass};
      end
      ST_LP_R: begin
        mul_a = {{(AW-ZW){dlp_r[ZW-1]}}, dlp_r};
        mul_b = {1'b0, coef.lowpass};
      end
      ST_HP_L: begin
        mul_a = {{(AW-ZW){dhp_l[ZW-1]}}, dhp_l};
        mul_b = {1'b0, coef.highpass};
      end
      ST_HP_R: begin
        mul_a = {{(AW-ZW){dhp_r[ZW-1]}}, dhp_r};
        mul_b = {1'b0, coef.highpass};
      end
      ST_PAN_L: begin
        mul_a = {{(AW-ZW){dhp_l[ZW-1]}}, dhp_l};
        mul_b = {1'b0, pan_c};
      end
      ST_PAN_R: begin
        mul_a = {{(AW-ZW){dhp_r[ZW-1]}}, dhp_r};
        mul_b = {1'b0, UNITY_Q15 - pan_c};
      end
      ST_FB_L: begin
        mul_a = acc_l_r;
        mul_b = {1'b0, fb_c};
      end
      ST_FB_R: begin
        mul_a = acc_r_r;
        mul_b = {1'b0, fb_c};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Each step consumes the product issued in the step before it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_l_r <= '0;
      lp_r_r <= '0;
      hp_l_r <= '0;
      hp_r_r <= '0;
    end else begin
      case (ctrl.step)
        ST_LP_R:  lp_l_r <= lp_l_r + sh16;
        ST_HP_L:  lp_r_r <= lp_r_r + sh16;
        ST_HP_R:  hp_l_r <= hp_l_r + sh16;
        ST_PAN_L: hp_r_r <= hp_r_r + sh16;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step == ST_PAN_R) begin
      acc_l_r <= fb_l;
    end
    if (ctrl.step == ST_FB_L) begin
      acc_r_r <= fb_r;
    end
  end

  // Feedback sample, saturated to the sample width.
  always_comb begin
    if (sh23 > SAT_HI) begin
      wr_sample = SAT_HI[SB-1:0];
    end else if (sh23 < SAT_LO) begin
      wr_sample = SAT_LO[SB-1:0];
    end else begin
      wr_sample = sh23[SB-1:0];
    end
  end

endmodule

[tb/sv/stereo_ping_pong_delay_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo ping-pong delay regression
// Sends stereo frames through the delay under random idling on both channels
// and checks every result against a cycle-free model of the tone filter,
// cross-feed and delay lines, or a typed-in value. Registers change between phases.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay_test;
  import spd_pkg::*;

  localparam int DELAY_DEPTH = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);

  localparam int      CLK_PERIOD    = 10;
  localparam int      RESET_CYCLES  = 7;
  localparam int      SETTLE_CYCLES = 30;
  localparam longint  LIMIT_NS      = 4_000_000;
  localparam int      PHASES        = 10;
  localparam int      PHASE_FRAMES  = 123;

  // The pan share is Q1.15 and the path is scaled by two, hence a 14-bit shift.
  localparam int PAN_SHIFT  = 14;
  localparam int GAIN_SHIFT = 15;
  localparam int COEF_SHIFT = 16;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] left;
    logic signed [OUT_BITS-1:0] right;
  } stereo_out_t;

  // A directed row is a register write, a frame checked against the model, or
  // a frame whose result is typed in because the delayed sample is known zero.
  typedef enum logic [1:0] {ROW_REG, ROW_FRAME, ROW_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [CFG_IDX_W-1:0]          index;
    logic [COEF_W-1:0]             value;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [OUT_BITS-1:0]    exp_left;
    logic signed [OUT_BITS-1:0]    exp_right;
  } row_t;

  localparam int DIRECTED_ROWS = 41;

  // The first frames run with the reset delay of 24000, so every delayed
  // sample is zero and each result is simply the dry input. The same holds
  // for a zero delay length (it reads the slot about to be written, not yet
  // written since reset here) and for the longest delay.
  row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_KNOWN, '0, '0, 16'sh0000, 16'sh0000, 17'sh00000, 17'sh00000},
    '{ROW_KNOWN, '0, '0, 16'sh7FFF, 16'sh8000, 17'sh07FFF, 17'sh18000},
    '{ROW_KNOWN, '0, '0, 16'sh8000, 16'sh7FFF, 17'sh18000, 17'sh07FFF},
    '{ROW_KNOWN, '0, '0, 16'shFFFF, 16'sh0001, 17'sh1FFFF, 17'sh00001},
    '{ROW_KNOWN, '0, '0, 16'sh5555, 16'shAAAA, 17'sh05555, 17'sh1AAAA},
    '{ROW_KNOWN, '0, '0, 16'shAAAA, 16'sh5555, 17'sh1AAAA, 17'sh05555},
    // Shortest delay, unity feedback and all of the input on the left.
    '{ROW_REG, REG_DELAY_LENGTH,  16'd1,     '0, '0, '0, '0},
    '{ROW_REG, REG_FEEDBACK_GAIN, 16'd32768, '0, '0, '0, '0},
    '{ROW_REG, REG_PAN_AMOUNT,    16'd32768, '0, '0, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh7FFF, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh8000, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh0000, 16'sh0000, '0, '0},
    // Gains above unity are clamped to unity.
    '{ROW_REG, REG_FEEDBACK_GAIN, 16'd65535, '0, '0, '0, '0},
    '{ROW_REG, REG_PAN_AMOUNT,    16'd65535, '0, '0, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, '0, '0},
    // All of the input on the right, low-pass wide open, high-pass off.
    '{ROW_REG, REG_PAN_AMOUNT,     16'd0,     '0, '0, '0, '0},
    '{ROW_REG, REG_LOWPASS_COEFF,  16'd65535, '0, '0, '0, '0},
    '{ROW_REG, REG_HIGHPASS_COEFF, 16'd0,     '0, '0, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh7FFF, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh8000, '0, '0},
    // Low-pass frozen, high-pass at its fastest.
    '{ROW_REG, REG_LOWPASS_COEFF,  16'd0,     '0, '0, '0, '0},
    '{ROW_REG, REG_HIGHPASS_COEFF, 16'd65535, '0, '0, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sd12345, -16'sd12345, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, '0, '0},
    // Writes to unmapped indexes are ignored.
    '{ROW_REG, REG_UNMAPPED_FIRST, 16'd0,     '0, '0, '0, '0},
    '{ROW_REG, REG_UNMAPPED_LAST,  16'd65535, '0, '0, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'shFFFF, '0, '0},
    '{ROW_REG, REG_DELAY_LENGTH, 16'd0, '0, '0, '0, '0},
    '{ROW_KNOWN, '0, '0, 16'sd1000, -16'sd1000, 17'sd1000, -17'sd1000},
    '{ROW_KNOWN, '0, '0, 16'sh8000, 16'sh7FFF, 17'sh18000, 17'sh07FFF},
    '{ROW_REG, REG_DELAY_LENGTH, 16'd65535, '0, '0, '0, '0},
    '{ROW_KNOWN, '0, '0, 16'sh7FFF, 16'sh7FFF, 17'sh07FFF, 17'sh07FFF},
    '{ROW_KNOWN, '0, '0, 16'shFFFF, 16'shFFFF, 17'sh1FFFF, 17'sh1FFFF},
    // Back to ordinary filter settings with a two-frame delay.
    '{ROW_REG, REG_DELAY_LENGTH,   16'd2,     '0, '0, '0, '0},
    '{ROW_REG, REG_LOWPASS_COEFF,  16'd32768, '0, '0, '0, '0},
    '{ROW_REG, REG_HIGHPASS_COEFF, 16'd128,   '0, '0, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sd20000, -16'sd20000, '0, '0},
    '{ROW_FRAME, '0, '0, -16'sd20000, 16'sd20000, '0, '0},
    '{ROW_FRAME, '0, '0, 16'sd5, -16'sd7, '0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  spd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  spd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  stereo_ping_pong_delay #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Model state: both delay lines, the shared write position, and the filter
  // accumulators (index 0 is left, 1 is right) with eight extra fraction bits.
  logic signed [SAMPLE_BITS-1:0] left_line  [DELAY_DEPTH];
  logic signed [SAMPLE_BITS-1:0] right_line [DELAY_DEPTH];
  logic [ADDR_W-1:0] line_wr_pos;
  longint lowpass_acc  [2];
  longint highpass_acc [2];

  // Model copy of the registers.
  logic [COEF_W-1:0] dly_len, fb_gain, pan_amt, lp_coef, hp_coef;

  stereo_out_t pending_outputs [$];
  int mismatches   = 0;
  int results_seen = 0;

  // Random idling controls in percent: gap_odds per frame sent, stall_odds at each falling clock edge outside a stall.
  int gap_odds   = 0;
  int stall_odds = 0;
  int stall_left = 0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // One channel of the tone filter: a one-pole low-pass, then the low-pass
  // output minus a second one-pole low-pass of it, which forms the high-pass.
  function automatic longint tone_stage(input longint x, input int ch);
    lowpass_acc[ch] += (longint'(lp_coef) * ((x <<< FILT_EXTRA) - lowpass_acc[ch]))
                       >>> COEF_SHIFT;
    highpass_acc[ch] += (longint'(hp_coef) * (lowpass_acc[ch] - highpass_acc[ch]))
                        >>> COEF_SHIFT;
    return lowpass_acc[ch] - highpass_acc[ch];
  endfunction

  // Sample written back into a line: the opposite line's tap plus the panned
  // filter output, scaled by the feedback gain and saturated to sample width.
  function automatic logic signed [SAMPLE_BITS-1:0] cross_feed(
    input longint tap, input longint shaped, input longint share, input longint gain);
    longint acc;
    longint w;
    acc = (tap <<< FILT_EXTRA) + ((shaped * share) >>> PAN_SHIFT);
    w = (acc * gain) >>> (GAIN_SHIFT + FILT_EXTRA);
    if (w > SAMPLE_MAX)
      w = SAMPLE_MAX;
    else if (w < SAMPLE_MIN)
      w = SAMPLE_MIN;
    return SAMPLE_BITS'(w);
  endfunction

  // Advances the model by one frame and returns the result it must produce.
  // Both lines are read before they are written.
  function automatic stereo_out_t advance_delay_line(
    input logic signed [SAMPLE_BITS-1:0] dry_l, input logic signed [SAMPLE_BITS-1:0] dry_r);
    logic [ADDR_W-1:0] rd_pos;
    longint pan, gain, tap_l, tap_r, shaped_l, shaped_r;
    stereo_out_t res;
    rd_pos = line_wr_pos - ADDR_W'(dly_len);
    pan  = (pan_amt > UNITY_Q15) ? longint'(UNITY_Q15) : longint'(pan_amt);
    gain = (fb_gain > UNITY_Q15) ? longint'(UNITY_Q15) : longint'(fb_gain);
    tap_l = longint'(left_line[rd_pos]);
    tap_r = longint'(right_line[rd_pos]);
    shaped_l = tone_stage(longint'(dry_l), 0);
    shaped_r = tone_stage(longint'(dry_r), 1);
    left_line[line_wr_pos]  = cross_feed(tap_r, shaped_l, pan, gain);
    right_line[line_wr_pos] = cross_feed(tap_l, shaped_r, longint'(UNITY_Q15) - pan, gain);
    line_wr_pos = line_wr_pos + ADDR_W'(1);
    res.left  = OUT_BITS'(tap_l + longint'(dry_l));
    res.right = OUT_BITS'(tap_r + longint'(dry_r));
    return res;
  endfunction

  // Presents one frame, optionally after an idle burst, and waits for the
  // transaction. Called and returns at a falling edge with valid still high,
  // so the next frame follows back to back unless the caller lowers it.
  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                            input logic signed [SAMPLE_BITS-1:0] r,
                            input bit known, input stereo_out_t typed);
    stereo_out_t want;
    if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_left  <= l;
    in_ch.in_right <= r;
    do @(posedge clk); while (!in_ch.ready);
    want = advance_delay_line(l, r);
    pending_outputs.push_back(known ? typed : want);
    @(negedge clk);
  endtask

  // Stops sending and waits until every result is back, so that the block is
  // idle before the registers change.
  task automatic drain_frames();
    in_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
  endtask

  // One register write, mirrored into the model's copy of the registers.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DELAY_LENGTH:   dly_len = val;
      REG_FEEDBACK_GAIN:  fb_gain = val;
      REG_PAN_AMOUNT:     pan_amt = val;
      REG_LOWPASS_COEFF:  lp_coef = val;
      REG_HIGHPASS_COEFF: hp_coef = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Gains are mostly uniform up to unity, with zero, exact unity and the
  // clamped region above unity each drawn now and then.
  function automatic logic [COEF_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return UNITY_Q15;
      2:       return COEF_W'($urandom_range(32769, 65535));
      default: return COEF_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Mostly full-range noise; full-scale steps and held values drive the
  // high-pass hard and push the feedback path into saturation.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
    input logic signed [SAMPLE_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return SAMPLE_BITS'(SAMPLE_MAX);
      1:       return SAMPLE_BITS'(SAMPLE_MIN);
      2, 3:    return prev;
      4:       return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Result side: ready drops in random bursts while stall_odds is nonzero.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
      stall_left = $urandom_range(0, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted result is compared with the oldest outstanding frame.
  always @(posedge clk) begin
    stereo_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with no frame outstanding",
                                results_seen));
      end else begin
        want = pending_outputs.pop_front();
        if (out_ch.out_left !== want.left)
          flag_mismatch($sformatf("result %0d out_left got %0d expected %0d",
                                  results_seen, out_ch.out_left, want.left));
        if (out_ch.out_right !== want.right)
          flag_mismatch($sformatf("result %0d out_right got %0d expected %0d",
                                  results_seen, out_ch.out_right, want.right));
      end
      results_seen++;
    end
  end

  initial begin
    row_t row;
    logic signed [SAMPLE_BITS-1:0] l, r;

    // Everything the block sees is known from time zero.
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_DELAY_LENGTH;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_left  = '0;
    in_ch.in_right = '0;
    out_ch.ready   = 1'b0;

    // The model starts from the reset state: empty lines, settled filters,
    // and the documented register defaults.
    for (int i = 0; i < DELAY_DEPTH; i++) begin
      left_line[i]  = '0;
      right_line[i] = '0;
    end
    line_wr_pos = '0;
    lowpass_acc  = '{0, 0};
    highpass_acc = '{0, 0};
    dly_len = COEF_W'(DELAY_LENGTH_RESET);
    fb_gain = FEEDBACK_GAIN_RESET;
    pan_amt = PAN_AMOUNT_RESET;
    lp_coef = LOWPASS_COEFF_RESET;
    hp_coef = HIGHPASS_COEFF_RESET;
    l = '0;
    r = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows, with light idling on both sides.
    gap_odds   = 15;
    stall_odds = 15;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_REG: begin
          drain_frames();
          write_reg(row.index, row.value);
        end
        ROW_FRAME: send_frame(row.left, row.right, 1'b0, '0);
        default:   send_frame(row.left, row.right, 1'b1, {row.exp_left, row.exp_right});
      endcase
    end

    // Random phases. Each starts idle with a fresh draw of every register;
    // delays are mostly short so that written samples come back around and
    // cross-feed within the phase. The last phase runs with no idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_frames();
      if (phase == PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = 10 * $urandom_range(0, 3);
        stall_odds = 10 * $urandom_range(0, 3);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
                  COEF_W'($urandom));
      case ($urandom_range(0, 7))
        0:       write_reg(REG_DELAY_LENGTH, 16'd1);
        1:       write_reg(REG_DELAY_LENGTH, 16'd0);
        2:       write_reg(REG_DELAY_LENGTH, '1);
        3:       write_reg(REG_DELAY_LENGTH, COEF_W'($urandom_range(2, 8)));
        4, 5:    write_reg(REG_DELAY_LENGTH, COEF_W'($urandom_range(9, 150)));
        6:       write_reg(REG_DELAY_LENGTH, COEF_W'($urandom_range(151, 1000)));
        default: write_reg(REG_DELAY_LENGTH, COEF_W'($urandom));
      endcase
      write_reg(REG_FEEDBACK_GAIN, pick_gain());
      write_reg(REG_PAN_AMOUNT, pick_gain());
      write_reg(REG_LOWPASS_COEFF, pick_coeff());
      write_reg(REG_HIGHPASS_COEFF, pick_coeff());
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        l = pick_sample(l);
        r = pick_sample(r);
        send_frame(l, r, 1'b0, '0);
      end
    end

    // Wait out the last results, then a little longer to catch strays.
    drain_frames();
    stall_odds = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("stereo_ping_pong_delay regression: pass");
    else
      $display("stereo_ping_pong_delay regression: fail");
    $finish;
  end

  // Watchdog for a block that stops handshaking.
  initial begin
    #(LIMIT_NS);
    $display("stereo_ping_pong_delay regression: fail");
    $finish;
  end

endmodule

[stereo_ping_pong_delay.f]
hw/rtl/spd_pkg.sv
hw/rtl/spd_in_if.sv
hw/rtl/spd_out_if.sv
hw/rtl/spd_ram.sv
hw/rtl/spd_datapath.sv
hw/rtl/stereo_ping_pong_delay.sv
tb/sv/stereo_ping_pong_delay_test.sv
